// ===== sv/mgcd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Masked graph cycle detector package
// Field widths, function codes and the command and status groups that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package mgcd_pkg;

    localparam int FUNC_W = 1;
    localparam int VTX_W  = 5;
    localparam int MASK_W = 32;
    localparam int CNT_W  = 6;

    localparam int MAX_VERTICES_DEF = 32;

    localparam logic [CNT_W-1:0] VCOUNT_RESET = 6'd32;

    localparam logic [FUNC_W-1:0] FUNC_ADD   = 1'b0;
    localparam logic [FUNC_W-1:0] FUNC_QUERY = 1'b1;

    // Commands from the controller; at most one step command is high per cycle.
    typedef struct packed {
        logic load_item;
        logic add_rd_a;
        logic add_wr_a;
        logic add_rd_b;
        logic add_wr_b;
        logic q_seek;
        logic q_expand;
        logic q_pop;
        logic finish;
    } dp_cmd_t;

    typedef struct packed {
        logic is_query;
        logic in_range;
        logic root_found;
        logic back_edge;
        logic nbr_found;
        logic stack_empty;
        logic out_busy;
    } dp_sts_t;

endpackage

// ===== sv/mgcd_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Masked graph cycle detector channels
// Item, result and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface mgcd_item_if;
    logic                          valid;
    logic                          ready;
    logic [mgcd_pkg::FUNC_W-1:0]   func;
    logic [mgcd_pkg::VTX_W-1:0]    first_vertex;
    logic [mgcd_pkg::VTX_W-1:0]    second_vertex;
    logic [mgcd_pkg::MASK_W-1:0]   excluded_mask;

    modport source (output valid, func, first_vertex, second_vertex, excluded_mask,
                    input ready);
    modport sink   (input valid, func, first_vertex, second_vertex, excluded_mask,
                    output ready);
endinterface

interface mgcd_result_if;
    logic valid;
    logic ready;
    logic cyclic;
    logic edge_taken;

    modport source (output valid, cyclic, edge_taken, input ready);
    modport sink   (input valid, cyclic, edge_taken, output ready);
endinterface

interface mgcd_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [mgcd_pkg::CNT_W-1:0]  data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// ===== sv/mgcd_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Masked graph cycle detector datapath
// Adjacency memory, walk stack, visited set, vertex count register and the
// result register, driven step by step by the controller.
// ----------------------------------------------------------------------------
module mgcd_datapath #(
    parameter int MAX_VERTICES = mgcd_pkg::MAX_VERTICES_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [mgcd_pkg::CNT_W-1:0]   cfg_data,
    input  logic [mgcd_pkg::FUNC_W-1:0]  item_func,
    input  logic [mgcd_pkg::VTX_W-1:0]   item_first,
    input  logic [mgcd_pkg::VTX_W-1:0]   item_second,
    input  logic [mgcd_pkg::MASK_W-1:0]  item_mask,
    input  logic                         res_ready,
    output logic                         res_valid,
    output logic                         res_cyclic,
    output logic                         res_edge_taken,
    input  mgcd_pkg::dp_cmd_t            cmd,
    output mgcd_pkg::dp_sts_t            sts
);

    localparam int VW   = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CW   = $clog2(MAX_VERTICES + 1);
    localparam int CMPW = (CW > mgcd_pkg::VTX_W) ? CW : mgcd_pkg::VTX_W;

    typedef logic [MAX_VERTICES-1:0] vmask_t;

    function automatic logic [VW-1:0] lowest_idx(input vmask_t v);
        logic [VW-1:0] idx;
        idx = '0;
        for (int i = MAX_VERTICES - 1; i >= 0; i--) begin
            if (v[i])
            begin
                idx = VW'(i);
            end
        end
        return idx;
    endfunction

    function automatic vmask_t onehot(input logic [VW-1:0] i);
        return vmask_t'(1) << i;
    endfunction

    // Storage
    vmask_t                      adj_mem [MAX_VERTICES];
    vmask_t                      row_vld_reg;
    vmask_t                      adj_rd_reg;
    logic                        rd_vld_reg;
    logic [VW-1:0]               stk_mem [MAX_VERTICES];
    logic [VW-1:0]               stk_rd_reg;

    logic [mgcd_pkg::CNT_W-1:0]  vc_reg;
    logic [mgcd_pkg::FUNC_W-1:0] func_reg;
    logic [mgcd_pkg::VTX_W-1:0]  a_reg;
    logic [mgcd_pkg::VTX_W-1:0]  b_reg;
    vmask_t                      keep_reg;
    vmask_t                      visited_reg;
    logic [VW-1:0]               cur_reg;
    logic [VW-1:0]               par_reg;
    logic                        has_par_reg;
    logic                        check_reg;
    logic [VW-1:0]               depth_reg;
    logic                        cyc_reg;
    logic                        res_valid_reg;
    logic                        res_cyc_reg;
    logic                        res_taken_reg;

    // Combinational view
    logic [CW-1:0]  eff;
    vmask_t         in_use;
    logic           in_range;
    logic [VW-1:0]  a_idx;
    logic [VW-1:0]  b_idx;
    vmask_t         row;
    vmask_t         nbr_all;
    vmask_t         par_mask;
    vmask_t         back;
    vmask_t         fresh;
    vmask_t         left;
    logic [VW-1:0]  nbr_idx;
    logic [VW-1:0]  root_idx;
    logic           back_edge;
    logic           push;
    logic           pop;
    logic           root_take;

    logic           adj_re;
    logic [VW-1:0]  adj_raddr;
    logic           adj_we;
    logic [VW-1:0]  adj_waddr;
    vmask_t         adj_wdata;

    assign eff = (int'(vc_reg) > MAX_VERTICES) ? CW'(MAX_VERTICES) : CW'(vc_reg);

    always_comb
    begin
        for (int i = 0; i < MAX_VERTICES; i++) begin
            in_use[i] = (i < int'(eff));
        end
    end

    assign in_range = (CMPW'(a_reg) < CMPW'(eff)) && (CMPW'(b_reg) < CMPW'(eff));
    assign a_idx    = VW'(a_reg);
    assign b_idx    = VW'(b_reg);

    // A row never written since reset reads as empty.
    assign row       = rd_vld_reg ? adj_rd_reg : '0;
    assign nbr_all   = row & keep_reg;
    assign par_mask  = has_par_reg ? onehot(par_reg) : '0;
    // The current vertex is already visited, so a self-loop shows up here too.
    assign back      = nbr_all & visited_reg & ~par_mask;
    assign fresh     = nbr_all & ~visited_reg;
    assign left      = keep_reg & ~visited_reg;
    assign nbr_idx   = lowest_idx(fresh);
    assign root_idx  = lowest_idx(left);
    assign back_edge = check_reg && (|back);

    assign push      = cmd.q_expand && !back_edge && (|fresh);
    assign pop       = cmd.q_expand && !back_edge && !(|fresh) && (depth_reg != '0);
    assign root_take = cmd.q_seek && (|left);

    assign sts.is_query    = (func_reg == mgcd_pkg::FUNC_QUERY);
    assign sts.in_range    = in_range;
    assign sts.root_found  = |left;
    assign sts.back_edge   = back_edge;
    assign sts.nbr_found   = |fresh;
    assign sts.stack_empty = (depth_reg == '0);
    assign sts.out_busy    = res_valid_reg && !res_ready;

    always_comb
    begin
        adj_re    = 1'b0;
        adj_raddr = a_idx;
        adj_we    = 1'b0;
        adj_waddr = a_idx;
        adj_wdata = row | onehot(b_idx);
        if (cmd.add_rd_a)
        begin
            adj_re = 1'b1;
        end
        if (cmd.add_wr_a)
        begin
            adj_we = 1'b1;
        end
        if (cmd.add_rd_b)
        begin
            adj_re    = 1'b1;
            adj_raddr = b_idx;
        end
        if (cmd.add_wr_b)
        begin
            adj_we    = 1'b1;
            adj_waddr = b_idx;
            adj_wdata = row | onehot(a_idx);
        end
        if (root_take)
        begin
            adj_re    = 1'b1;
            adj_raddr = root_idx;
        end
        if (push)
        begin
            adj_re    = 1'b1;
            adj_raddr = nbr_idx;
        end
        if (cmd.q_pop)
        begin
            adj_re    = 1'b1;
            adj_raddr = stk_rd_reg;
        end
    end

    // Adjacency memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (adj_we)
        begin
            adj_mem[adj_waddr] <= adj_wdata;
        end
        if (adj_re)
        begin
            adj_rd_reg <= adj_mem[adj_raddr];
        end
    end

    // Walk stack memory.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            stk_mem[depth_reg] <= cur_reg;
        end
        if (pop)
        begin
            stk_rd_reg <= stk_mem[depth_reg - VW'(1)];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_vld_reg   <= '0;
            rd_vld_reg    <= 1'b0;
            vc_reg        <= mgcd_pkg::VCOUNT_RESET;
            visited_reg   <= '0;
            depth_reg     <= '0;
            cyc_reg       <= 1'b0;
            has_par_reg   <= 1'b0;
            check_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (adj_we)
            begin
                row_vld_reg[adj_waddr] <= 1'b1;
            end
            if (adj_re)
            begin
                rd_vld_reg <= row_vld_reg[adj_raddr];
            end
            if (cfg_we)
            begin
                vc_reg <= cfg_data;
            end

            if (cmd.load_item)
            begin
                visited_reg <= '0;
                depth_reg   <= '0;
                cyc_reg     <= 1'b0;
            end
            if (root_take)
            begin
                visited_reg <= visited_reg | onehot(root_idx);
                has_par_reg <= 1'b0;
                check_reg   <= 1'b1;
            end
            if (cmd.q_expand && back_edge)
            begin
                cyc_reg <= 1'b1;
            end
            if (push)
            begin
                visited_reg <= visited_reg | onehot(nbr_idx);
                depth_reg   <= depth_reg + VW'(1);
                has_par_reg <= 1'b1;
                check_reg   <= 1'b1;
            end
            if (pop)
            begin
                depth_reg <= depth_reg - VW'(1);
            end
            if (cmd.q_pop)
            begin
                check_reg <= 1'b0;
            end

            if (cmd.finish)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            func_reg <= item_func;
            a_reg    <= item_first;
            b_reg    <= item_second;
            keep_reg <= in_use & ~vmask_t'(item_mask);
        end
        if (root_take)
        begin
            cur_reg <= root_idx;
        end
        if (push)
        begin
            cur_reg <= nbr_idx;
            par_reg <= cur_reg;
        end
        if (cmd.q_pop)
        begin
            cur_reg <= stk_rd_reg;
        end
        if (cmd.finish)
        begin
            res_cyc_reg   <= (func_reg == mgcd_pkg::FUNC_QUERY) && cyc_reg;
            res_taken_reg <= (func_reg == mgcd_pkg::FUNC_ADD) && in_range;
        end
    end

    assign res_valid      = res_valid_reg;
    assign res_cyclic     = res_cyc_reg;
    assign res_edge_taken = res_taken_reg;

endmodule

// ===== sv/mgcd_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Masked graph cycle detector controller
// Sequences edge insertion and the depth-first walk of a cycle query.
// ----------------------------------------------------------------------------
module mgcd_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output mgcd_pkg::dp_cmd_t  cmd,
    input  mgcd_pkg::dp_sts_t  sts
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_DECODE = 4'd1;
    localparam logic [3:0] ST_ADD_RA = 4'd2;
    localparam logic [3:0] ST_ADD_WA = 4'd3;
    localparam logic [3:0] ST_ADD_RB = 4'd4;
    localparam logic [3:0] ST_ADD_WB = 4'd5;
    localparam logic [3:0] ST_SEEK   = 4'd6;
    localparam logic [3:0] ST_EXPAND = 4'd7;
    localparam logic [3:0] ST_POP    = 4'd8;
    localparam logic [3:0] ST_FIN    = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (sts.is_query)
                begin
                    state_next = ST_SEEK;
                end
                else if (sts.in_range)
                begin
                    state_next = ST_ADD_RA;
                end
                else
                begin
                    state_next = ST_FIN;
                end
            end
            ST_ADD_RA:
            begin
                cmd.add_rd_a = 1'b1;
                state_next   = ST_ADD_WA;
            end
            ST_ADD_WA:
            begin
                cmd.add_wr_a = 1'b1;
                state_next   = ST_ADD_RB;
            end
            ST_ADD_RB:
            begin
                cmd.add_rd_b = 1'b1;
                state_next   = ST_ADD_WB;
            end
            ST_ADD_WB:
            begin
                cmd.add_wr_b = 1'b1;
                state_next   = ST_FIN;
            end
            ST_SEEK:
            begin
                cmd.q_seek = 1'b1;
                state_next = sts.root_found ? ST_EXPAND : ST_FIN;
            end
            ST_EXPAND:
            begin
                cmd.q_expand = 1'b1;
                priority if (sts.back_edge)
                begin
                    state_next = ST_FIN;
                end
                else if (sts.nbr_found)
                begin
                    state_next = ST_EXPAND;
                end
                else if (sts.stack_empty)
                begin
                    state_next = ST_SEEK;
                end
                else
                begin
                    state_next = ST_POP;
                end
            end
            ST_POP:
            begin
                cmd.q_pop  = 1'b1;
                state_next = ST_EXPAND;
            end
            ST_FIN:
            begin
                if (!sts.out_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== sv/masked_graph_cycle_detector.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Masked graph cycle detector
// Undirected graph store with add-edge items and masked cycle queries.
// ----------------------------------------------------------------------------
// Items arrive on the items channel and each one returns exactly one result
// transaction on the results channel. An add item (func 0) sets both matrix
// bits of the vertex pair and reports edge_taken; a query item (func 1) runs
// a depth-first walk over the vertices not named in excluded_mask and reports
// cyclic. The cfg channel writes the vertex count and is always ready. The
// user must write it only while no item is in flight; the block does not check.
// One item is processed at a time. An add item reads and writes the row of
// its first vertex, then of its second, before its result; an add item with
// an endpoint out of range goes straight to its result. A query seeks a new
// root for every connected group it walks, expands once for every vertex
// discovered, and pops then expands again for every step back up the walk;
// a cycle found ends the walk early. Every step waits on the single read port
// of the adjacency memory. The next item is accepted in the cycle after the
// result is loaded, even if that result is still waiting.
// Reset empties the graph and sets the vertex count to 32. When the receiver
// stalls, the result is held and the block stops before loading the next one.
// ----------------------------------------------------------------------------
module masked_graph_cycle_detector #(
    parameter int MAX_VERTICES = mgcd_pkg::MAX_VERTICES_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    mgcd_item_if.sink      items,
    mgcd_result_if.source  results,
    mgcd_cfg_if.sink       cfg
);

    mgcd_pkg::dp_cmd_t cmd;
    mgcd_pkg::dp_sts_t sts;
    logic              in_ready;

    assign items.ready = in_ready;
    assign cfg.ready   = 1'b1;

    mgcd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (items.valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .sts      (sts)
    );

    mgcd_datapath #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg.valid),
        .cfg_data       (cfg.data),
        .item_func      (items.func),
        .item_first     (items.first_vertex),
        .item_second    (items.second_vertex),
        .item_mask      (items.excluded_mask),
        .res_ready      (results.ready),
        .res_valid      (results.valid),
        .res_cyclic     (results.cyclic),
        .res_edge_taken (results.edge_taken),
        .cmd            (cmd),
        .sts            (sts)
    );

endmodule

// ===== sv/mgcd_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Masked graph cycle detector checker
// Port-level properties of the item and result channels.
// ----------------------------------------------------------------------------
module mgcd_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic res_valid,
    input logic res_ready,
    input logic res_cyclic,
    input logic res_edge_taken
);

    // A result is never both a stored edge and a found cycle.
    a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !(res_cyclic && res_edge_taken))
        else $error("result flags both set");

    // In the cycle after an item transaction the block is busy.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("item accepted in back-to-back cycles");

    // A new result only appears while no item could have been accepted.
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> !$past(in_ready))
        else $error("result appeared without work in progress");

    // A stalled result stays offered.
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> res_valid)
        else $error("result dropped while stalled");

endmodule

bind masked_graph_cycle_detector mgcd_checker u_mgcd_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (items.valid),
    .in_ready       (items.ready),
    .res_valid      (results.valid),
    .res_ready      (results.ready),
    .res_cyclic     (results.cyclic),
    .res_edge_taken (results.edge_taken)
);

// ===== tb/graph_answer_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Graph answer checker
// Watches the item, result and configuration channels of the masked graph
// cycle detector. It keeps its own adjacency matrix and vertex count, works
// out the answer to every accepted item, and compares each result
// transaction with the oldest outstanding answer.
// ----------------------------------------------------------------------------
module graph_answer_checker (
    input  logic          clk,
    input  logic          rst_n,
    mgcd_item_if          items,
    mgcd_result_if        results,
    mgcd_cfg_if           cfg,
    output int            mismatches,
    output int            awaiting
);

    localparam int VERTICES = mgcd_pkg::MAX_VERTICES_DEF;

    typedef struct packed {
        logic cyclic;
        logic edge_taken;
    } answer_t;

    logic [VERTICES-1:0]          graph_rows [VERTICES];
    logic [mgcd_pkg::CNT_W-1:0]   vertex_limit;
    answer_t                      pending_answers [$];

    function automatic int active_vertices();
        return (vertex_limit > VERTICES) ? VERTICES : int'(vertex_limit);
    endfunction

    function automatic logic store_edge(logic [mgcd_pkg::VTX_W-1:0] a,
                                        logic [mgcd_pkg::VTX_W-1:0] b);
        int limit;
        limit = active_vertices();
        if (a >= limit || b >= limit)
            return 1'b0;
        graph_rows[a][b] = 1'b1;
        graph_rows[b][a] = 1'b1;
        return 1'b1;
    endfunction

    // A component holds a cycle when it has at least as many edges as
    // vertices; self-loops are caught first so edge ends always pair up.
    function automatic logic subgraph_has_cycle(logic [mgcd_pkg::MASK_W-1:0] excluded);
        int                  limit;
        int                  ends;
        logic [VERTICES-1:0] keep;
        logic [VERTICES-1:0] unseen;
        logic [VERTICES-1:0] comp;
        logic [VERTICES-1:0] grown;
        limit = active_vertices();
        keep = (limit >= VERTICES) ? '1 : ((VERTICES'(1) << limit) - 1'b1);
        keep &= ~excluded;
        for (int i = 0; i < VERTICES; i++)
            if (keep[i] && graph_rows[i][i])
                return 1'b1;
        unseen = keep;
        while (unseen != '0) begin
            comp = unseen & (~unseen + 1'b1);
            grown = '0;
            while (grown != comp) begin
                grown = comp;
                for (int i = 0; i < VERTICES; i++)
                    if (grown[i])
                        comp |= graph_rows[i] & keep;
            end
            ends = 0;
            for (int i = 0; i < VERTICES; i++)
                if (comp[i])
                    ends += $countones(graph_rows[i] & keep);
            unseen &= ~comp;
            if (ends / 2 >= $countones(comp))
                return 1'b1;
        end
        return 1'b0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        answer_t due;
        if (!rst_n)
        begin
            for (int i = 0; i < VERTICES; i++)
                graph_rows[i] = '0;
            vertex_limit = mgcd_pkg::VCOUNT_RESET;
            pending_answers.delete();
            mismatches = 0;
            awaiting <= 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
                vertex_limit = cfg.data;

            if (results.valid && results.ready)
            begin
                if (pending_answers.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: result transaction with no item outstanding %s",
                             $time, "(expected none)");
                    $display("%0t: actual cyclic %0b, edge_taken %0b",
                             $time, results.cyclic, results.edge_taken);
                end
                else
                begin
                    due = pending_answers.pop_front();
                    if (results.cyclic !== due.cyclic)
                    begin
                        mismatches++;
                        $display("%0t: cyclic expected %0b, actual %0b",
                                 $time, due.cyclic, results.cyclic);
                    end
                    if (results.edge_taken !== due.edge_taken)
                    begin
                        mismatches++;
                        $display("%0t: edge_taken expected %0b, actual %0b",
                                 $time, due.edge_taken, results.edge_taken);
                    end
                end
            end

            if (items.valid && items.ready)
            begin
                due.cyclic = 1'b0;
                due.edge_taken = 1'b0;
                if (items.func == mgcd_pkg::FUNC_ADD)
                    due.edge_taken = store_edge(items.first_vertex, items.second_vertex);
                else
                    due.cyclic = subgraph_has_cycle(items.excluded_mask);
                pending_answers.push_back(due);
            end

            awaiting <= pending_answers.size();
        end
    end

endmodule

// ===== tb/masked_graph_cycle_detector_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Masked graph cycle detector testbench
// Drives add-edge and masked cycle query items through a directed opening
// and random phases over several vertex counts and idling patterns, with
// an answer checker beside the block, and prints the verdict.
// ----------------------------------------------------------------------------
module masked_graph_cycle_detector_tb;

    localparam int PHASES = 8;
    localparam int VCOUNT_PLAN    [PHASES] = '{32, 9, 63, 4, 32, 1, 24, 0};
    localparam int ITEMS_PLAN     [PHASES] = '{240, 220, 200, 200, 220, 60, 220, 40};
    localparam int SEND_IDLE_PLAN [4]      = '{0, 60, 0, 38};
    localparam int STALL_PLAN     [4]      = '{0, 0, 60, 38};
    localparam int VTX_MAX                 = mgcd_pkg::MAX_VERTICES_DEF;

    logic clk = 1'b0;
    logic rst_n;
    int   sender_idle_pct = 0;
    int   stall_pct = 0;
    int   vertices_now = 32;
    int   mismatches;
    int   awaiting;

    mgcd_item_if   items ();
    mgcd_result_if results ();
    mgcd_cfg_if    cfg ();

    masked_graph_cycle_detector dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items),
        .results (results),
        .cfg     (cfg)
    );

    graph_answer_checker answer_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .items      (items),
        .results    (results),
        .cfg        (cfg),
        .mismatches (mismatches),
        .awaiting   (awaiting)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial
    begin
        #10_000_000;
        $display("masked_graph_cycle_detector_tb NOT OK");
        $finish;
    end

    initial
    begin
        results.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            results.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Leaves valid high after the transaction so back-to-back items need no
    // second assignment in the same step.
    task automatic offer_item(input logic [mgcd_pkg::FUNC_W-1:0] f,
                              input logic [mgcd_pkg::VTX_W-1:0]  a,
                              input logic [mgcd_pkg::VTX_W-1:0]  b,
                              input logic [mgcd_pkg::MASK_W-1:0] m);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            items.valid <= 1'b0;
            @(posedge clk);
        end
        items.valid         <= 1'b1;
        items.func          <= f;
        items.first_vertex  <= a;
        items.second_vertex <= b;
        items.excluded_mask <= m;
        do @(posedge clk); while (!items.ready);
    endtask

    task automatic add_edge(input logic [mgcd_pkg::VTX_W-1:0] a,
                            input logic [mgcd_pkg::VTX_W-1:0] b);
        offer_item(mgcd_pkg::FUNC_ADD, a, b, $urandom);
    endtask

    task automatic ask_cycle(input logic [mgcd_pkg::MASK_W-1:0] m);
        offer_item(mgcd_pkg::FUNC_QUERY, mgcd_pkg::VTX_W'($urandom),
                   mgcd_pkg::VTX_W'($urandom), m);
    endtask

    task automatic wait_for_answers();
        items.valid <= 1'b0;
        do @(posedge clk); while (awaiting != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_vertex_count(input logic [mgcd_pkg::CNT_W-1:0] v);
        wait_for_answers();
        cfg.valid <= 1'b1;
        cfg.data  <= v;
        do @(posedge clk); while (!cfg.ready);
        cfg.valid <= 1'b0;
        vertices_now = (v > VTX_MAX) ? VTX_MAX : int'(v);
    endtask

    initial
    begin
        logic [mgcd_pkg::VTX_W-1:0]  a;
        logic [mgcd_pkg::VTX_W-1:0]  b;
        logic [mgcd_pkg::MASK_W-1:0] mask;
        int                          r;
        int                          k;
        int                          top;

        rst_n               <= 1'b0;
        items.valid         <= 1'b0;
        items.func          <= mgcd_pkg::FUNC_ADD;
        items.first_vertex  <= '0;
        items.second_vertex <= '0;
        items.excluded_mask <= '0;
        cfg.valid           <= 1'b0;
        cfg.data            <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed opening at the reset vertex count.
        ask_cycle(32'h0);
        add_edge(5'd0, 5'd31);
        add_edge(5'd31, 5'd0);
        ask_cycle(32'h0);
        add_edge(5'd5, 5'd5);
        ask_cycle(32'h0);
        ask_cycle(32'h0000_0020);
        add_edge(5'd1, 5'd2);
        add_edge(5'd2, 5'd3);
        add_edge(5'd3, 5'd1);
        ask_cycle(32'h0000_0020);
        ask_cycle(32'h0000_0028);
        ask_cycle(32'hFFFF_FFFF);
        add_edge(5'd31, 5'd31);
        ask_cycle(32'h7FFF_FFFF);

        // Lowered count: edges above it stay stored but drop out of queries.
        write_vertex_count(6'd3);
        add_edge(5'd3, 5'd0);
        add_edge(5'd0, 5'd2);
        ask_cycle(32'h0);
        add_edge(5'd1, 5'd0);
        ask_cycle(32'h0);
        ask_cycle(32'hFFFF_FFF8);

        write_vertex_count(6'd0);
        add_edge(5'd0, 5'd0);
        ask_cycle(32'h0);

        write_vertex_count(6'd63);
        add_edge(5'd31, 5'd30);
        ask_cycle(32'h3FFF_FFFF);

        write_vertex_count(6'd1);
        add_edge(5'd0, 5'd1);
        add_edge(5'd0, 5'd0);
        ask_cycle(32'h0);

        for (int p = 0; p < PHASES; p++)
        begin
            write_vertex_count(mgcd_pkg::CNT_W'(VCOUNT_PLAN[p]));
            sender_idle_pct = SEND_IDLE_PLAN[p % 4];
            stall_pct       = STALL_PLAN[p % 4];
            for (int n = 0; n < ITEMS_PLAN[p]; n++)
            begin
                if (n == ITEMS_PLAN[p] / 2)
                    wait_for_answers();
                if ($urandom_range(3) == 0)
                begin
                    // Mostly in-range pairs; a few arbitrary ones get refused.
                    if (vertices_now == 0 || $urandom_range(9) == 0)
                    begin
                        a = mgcd_pkg::VTX_W'($urandom_range(31));
                        b = mgcd_pkg::VTX_W'($urandom_range(31));
                    end
                    else
                    begin
                        a = mgcd_pkg::VTX_W'($urandom_range(vertices_now - 1));
                        b = mgcd_pkg::VTX_W'($urandom_range(vertices_now - 1));
                        if (vertices_now > 1 && $urandom_range(99) >= 3)
                            while (b == a)
                                b = mgcd_pkg::VTX_W'($urandom_range(vertices_now - 1));
                    end
                    add_edge(a, b);
                end
                else
                begin
                    // Small kept sets keep the answer mixed as the graph fills up.
                    r = $urandom_range(99);
                    if (r < 50)
                    begin
                        k = $urandom_range(6, 1);
                        top = (vertices_now > 0) ? vertices_now - 1 : 31;
                        mask = '0;
                        repeat (k)
                            mask[$urandom_range(top)] = 1'b1;
                        mask = ~mask;
                    end
                    else if (r < 80)
                        mask = $urandom | $urandom;
                    else if (r < 90)
                        mask = $urandom;
                    else if (r < 95)
                        mask = '0;
                    else
                        mask = '1;
                    ask_cycle(mask);
                end
            end
        end

        wait_for_answers();
        repeat (120) @(posedge clk);
        if (mismatches == 0 && awaiting == 0)
            $display("masked_graph_cycle_detector_tb OK");
        else
            $display("masked_graph_cycle_detector_tb NOT OK");
        $finish;
    end

endmodule
